// File: rtl/core/sdq_pkg.sv
`default_nettype none

package sdq_pkg;

    // Command codes carried on the input channel.
    typedef enum logic [3:0] {
        CMD_ADD_FIRST  = 4'd0,
        CMD_ADD_LAST   = 4'd1,
        CMD_DEL_FIRST  = 4'd2,
        CMD_DEL_LAST   = 4'd3,
        CMD_CLEAR      = 4'd4,
        CMD_DEL_VALUE  = 4'd5,
        CMD_READ_ALL   = 4'd6,
        CMD_READ_FIRST = 4'd7,
        CMD_READ_LAST  = 4'd8
    } cmd_t;

    // Status codes carried on the result channel.
    typedef enum logic [1:0] {
        STAT_ELEMENT = 2'd0,
        STAT_EMPTY   = 2'd1,
        STAT_NOTHING = 2'd2,
        STAT_FULL    = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MARK,
        ST_STREAM,
        ST_DEL
    } state_t;

    localparam int unsigned DATA_W = 32;

endpackage

`default_nettype wire

// File: rtl/core/sdq_ram.sv
`default_nettype none

module sdq_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Read data holds its value until the next read is issued.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/sequence_deque_with_value_delete.sv
`default_nettype none

// Bounded double-ended queue of signed 32-bit values with delete-by-value.
// Input channel (s_valid/s_ready): one item is a command plus a value. Adds at
// either end, deletes at either end and clear finish in the accepting cycle and
// give no result, except an add to a full store, which gives one item with the
// full status. Delete-by-value walks the held entries through the entry memory,
// one per cycle, and the next command is taken once the walk has finished.
// Read commands stream the selected entries front to back on the result channel
// (m_valid/m_ready), m_last marking the final item; a read of an empty list or
// one that selects nothing gives a single marker item.
// Each streamed entry is read from the entry memory and then moved into the
// output register; items follow one per cycle while m_ready stays high, and the
// next command is taken in the cycle in which the last item shows up. A marker
// item is loaded into the output register from the mark state.
// Results sit in an output register, so the next command is accepted while the
// last result of the previous one still waits. When the receiver stalls, the
// stream pauses with one entry parked in the memory read register.
// Reset (aresetn low, synchronous) empties the list and drops any result in
// flight; the memory contents are not cleared.
module sequence_deque_with_value_delete #(
    parameter int unsigned CAPACITY = 64
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic        [3:0]  s_command,
    input  wire logic signed [31:0] s_value,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [31:0]      m_element,
    output logic        [1:0]       m_status,
    output logic                    m_last
);

    import sdq_pkg::*;

    localparam int unsigned IDX_W = $clog2(CAPACITY);
    localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
    localparam int unsigned SUM_W = CNT_W + 1;

    // Ring position of (idx + off) modulo CAPACITY; idx < CAPACITY, off <= CAPACITY.
    function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] idx,
                                                  input logic [CNT_W-1:0] off);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(idx) + SUM_W'(off);
        if (sum >= SUM_W'(CAPACITY)) begin
            sum = sum - SUM_W'(CAPACITY);
        end
        return sum[IDX_W-1:0];
    endfunction

    function automatic logic [IDX_W-1:0] ring_inc(input logic [IDX_W-1:0] idx);
        return (idx == IDX_W'(CAPACITY - 1)) ? '0 : idx + IDX_W'(1);
    endfunction

    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   front_reg, front_next;
    logic [CNT_W-1:0]   fill_reg, fill_next;
    logic [IDX_W-1:0]   rd_slot_reg, rd_slot_next;
    logic [IDX_W-1:0]   wr_slot_reg, wr_slot_next;
    logic [CNT_W-1:0]   issue_left_reg, issue_left_next;
    logic [CNT_W-1:0]   remain_reg, remain_next;
    logic [CNT_W-1:0]   kept_reg, kept_next;
    logic               pending_reg, pending_next;
    status_t            mark_reg, mark_next;
    logic [DATA_W-1:0]  val_reg, val_next;

    logic               m_valid_reg, m_valid_next;
    logic [DATA_W-1:0]  m_element_reg, m_element_next;
    status_t            m_status_reg, m_status_next;
    logic               m_last_reg, m_last_next;

    logic               ram_wr_en;
    logic [IDX_W-1:0]   ram_wr_addr;
    logic [DATA_W-1:0]  ram_wr_data;
    logic               ram_rd_en;
    logic [IDX_W-1:0]   ram_rd_addr;
    logic [DATA_W-1:0]  ram_rd_data;

    logic               accept;
    logic               out_free;
    logic               deliver;
    logic               issue;
    logic [DATA_W-1:0]  in_value;
    logic               val_below_fill;
    logic [CNT_W-1:0]   n_clip;

    sdq_ram #(
        .WIDTH(DATA_W),
        .DEPTH(CAPACITY)
    ) u_entry_ram (
        .aclk   (aclk),
        .wr_en  (ram_wr_en),
        .wr_addr(ram_wr_addr),
        .wr_data(ram_wr_data),
        .rd_en  (ram_rd_en),
        .rd_addr(ram_rd_addr),
        .rd_data(ram_rd_data)
    );

    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign in_value  = s_value;

    // The requested count n, clipped to the number of held entries.
    assign val_below_fill = in_value < DATA_W'(fill_reg);
    assign n_clip         = val_below_fill ? in_value[CNT_W-1:0] : fill_reg;

    assign m_valid   = m_valid_reg;
    assign m_element = m_element_reg;
    assign m_status  = m_status_reg;
    assign m_last    = m_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            front_reg      <= '0;
            fill_reg       <= '0;
            issue_left_reg <= '0;
            remain_reg     <= '0;
            kept_reg       <= '0;
            pending_reg    <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            front_reg      <= front_next;
            fill_reg       <= fill_next;
            issue_left_reg <= issue_left_next;
            remain_reg     <= remain_next;
            kept_reg       <= kept_next;
            pending_reg    <= pending_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rd_slot_reg   <= rd_slot_next;
        wr_slot_reg   <= wr_slot_next;
        mark_reg      <= mark_next;
        val_reg       <= val_next;
        m_element_reg <= m_element_next;
        m_status_reg  <= m_status_next;
        m_last_reg    <= m_last_next;
    end

    always_comb begin
        state_next      = state_reg;
        front_next      = front_reg;
        fill_next       = fill_reg;
        rd_slot_next    = rd_slot_reg;
        wr_slot_next    = wr_slot_reg;
        issue_left_next = issue_left_reg;
        remain_next     = remain_reg;
        kept_next       = kept_reg;
        pending_next    = pending_reg;
        mark_next       = mark_reg;
        val_next        = val_reg;

        m_valid_next    = m_ready ? 1'b0 : m_valid_reg;
        m_element_next  = m_element_reg;
        m_status_next   = m_status_reg;
        m_last_next     = m_last_reg;

        ram_wr_en   = 1'b0;
        ram_wr_addr = '0;
        ram_wr_data = in_value;
        ram_rd_en   = 1'b0;
        ram_rd_addr = rd_slot_reg;

        deliver = 1'b0;
        issue   = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (s_command)
                        CMD_ADD_FIRST, CMD_ADD_LAST: begin
                            if (fill_reg == CNT_W'(CAPACITY)) begin
                                mark_next  = STAT_FULL;
                                state_next = ST_MARK;
                            end else begin
                                ram_wr_en = 1'b1;
                                if (s_command == CMD_ADD_FIRST) begin
                                    front_next  = ring_add(front_reg, CNT_W'(CAPACITY - 1));
                                    ram_wr_addr = front_next;
                                end else begin
                                    ram_wr_addr = ring_add(front_reg, fill_reg);
                                end
                                fill_next = fill_reg + CNT_W'(1);
                            end
                        end
                        CMD_DEL_FIRST: begin
                            if (fill_reg != '0) begin
                                front_next = ring_inc(front_reg);
                                fill_next  = fill_reg - CNT_W'(1);
                            end
                        end
                        CMD_DEL_LAST: begin
                            if (fill_reg != '0) begin
                                fill_next = fill_reg - CNT_W'(1);
                            end
                        end
                        CMD_CLEAR: begin
                            fill_next  = '0;
                            front_next = '0;
                        end
                        CMD_DEL_VALUE: begin
                            if (fill_reg != '0) begin
                                val_next        = in_value;
                                rd_slot_next    = front_reg;
                                wr_slot_next    = front_reg;
                                issue_left_next = fill_reg;
                                kept_next       = '0;
                                pending_next    = 1'b0;
                                state_next      = ST_DEL;
                            end
                        end
                        CMD_READ_ALL, CMD_READ_FIRST, CMD_READ_LAST: begin
                            pending_next = 1'b0;
                            if (fill_reg == '0) begin
                                mark_next  = STAT_EMPTY;
                                state_next = ST_MARK;
                            end else if (s_command == CMD_READ_ALL ||
                                         (s_command == CMD_READ_FIRST && in_value[31])) begin
                                rd_slot_next    = front_reg;
                                issue_left_next = fill_reg;
                                remain_next     = fill_reg;
                                state_next      = ST_STREAM;
                            end else if (in_value[31] || in_value == '0) begin
                                // A zero count selects nothing, and so does a
                                // negative count for a read from the back.
                                mark_next  = STAT_NOTHING;
                                state_next = ST_MARK;
                            end else begin
                                if (s_command == CMD_READ_FIRST) begin
                                    rd_slot_next = front_reg;
                                end else begin
                                    rd_slot_next = ring_add(front_reg, fill_reg - n_clip);
                                end
                                issue_left_next = n_clip;
                                remain_next     = n_clip;
                                state_next      = ST_STREAM;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            ST_MARK: begin
                if (out_free) begin
                    m_valid_next   = 1'b1;
                    m_element_next = '0;
                    m_status_next  = mark_reg;
                    m_last_next    = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            ST_STREAM: begin
                // The entry in the memory read register moves out when the
                // output register frees up; the next read is issued in the
                // same cycle so that one item leaves per cycle while the receiver keeps up.
                deliver = pending_reg && out_free;
                issue   = (issue_left_reg != '0) && (!pending_reg || deliver);
                if (deliver) begin
                    m_valid_next   = 1'b1;
                    m_element_next = ram_rd_data;
                    m_status_next  = STAT_ELEMENT;
                    m_last_next    = (remain_reg == CNT_W'(1));
                    remain_next    = remain_reg - CNT_W'(1);
                    if (remain_reg == CNT_W'(1)) begin
                        state_next = ST_IDLE;
                    end
                end
                if (issue) begin
                    ram_rd_en       = 1'b1;
                    rd_slot_next    = ring_inc(rd_slot_reg);
                    issue_left_next = issue_left_reg - CNT_W'(1);
                end
                pending_next = issue || (pending_reg && !deliver);
            end

            ST_DEL: begin
                // Compaction: entries that differ from the value are written
                // back at the kept position, which never runs ahead of the
                // read position, so no read sees an entry already moved.
                if (pending_reg && ram_rd_data != val_reg) begin
                    ram_wr_en    = 1'b1;
                    ram_wr_addr  = wr_slot_reg;
                    ram_wr_data  = ram_rd_data;
                    wr_slot_next = ring_inc(wr_slot_reg);
                    kept_next    = kept_reg + CNT_W'(1);
                end
                issue = (issue_left_reg != '0);
                if (issue) begin
                    ram_rd_en       = 1'b1;
                    rd_slot_next    = ring_inc(rd_slot_reg);
                    issue_left_next = issue_left_reg - CNT_W'(1);
                end
                pending_next = issue;
                if (!pending_reg && !issue) begin
                    fill_next  = kept_reg;
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // The count never exceeds the store size.
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= CNT_W'(CAPACITY))
        else $error("fill count above capacity");

    // While streaming, every result still owed is either parked or not issued.
    a_stream_balance: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_STREAM |->
            remain_reg == issue_left_reg + CNT_W'(pending_reg))
        else $error("stream bookkeeping out of step");

    // Compaction can never keep more entries than were held.
    a_kept_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DEL |-> kept_reg <= fill_reg)
        else $error("kept count above fill count");

    // Marker items carry a zero element.
    a_marker_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != STAT_ELEMENT) |-> (m_element == '0 && m_last))
        else $error("marker item with element or without last");

    // A finished stream hands over its final item marked as last.
    a_stream_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_STREAM && deliver && remain_reg == CNT_W'(1)) |=>
            (m_valid && m_last && state_reg == ST_IDLE))
        else $error("stream ended without a last item");

endmodule

`default_nettype wire
